// File: sv/plt_pkg.sv
// Shared constants and types for the piecewise-linear lookup table.
`timescale 1ns / 1ps

package plt_pkg;

    // Table geometry
    localparam int POINTS_MAX = 256;
    localparam int IDX_W      = $clog2(POINTS_MAX);
    localparam int CNT_W      = $clog2(POINTS_MAX + 1);

    // Field widths
    localparam int DATA_W   = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;

    // Divider: quotient always fits the data width
    localparam int DIV_STEPS  = DATA_W;
    localparam int DIV_STEP_W = $clog2(DIV_STEPS);

    // Operation codes
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_INTERP  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_LOW     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_HIGH    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FEW     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_STORED  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd5;
    localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd6;

    // One stored sample point
    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
    } t_point;

endpackage

// File: sv/plt_in_if.sv
// Input channel: operation and point/argument, valid/ready handshake.
`timescale 1ns / 1ps

interface plt_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [plt_pkg::OP_W-1:0]              op;
    logic signed [plt_pkg::DATA_W-1:0]     x_value;
    logic signed [plt_pkg::DATA_W-1:0]     y_value;

    modport source (output valid, op, x_value, y_value, input ready);
    modport sink   (input valid, op, x_value, y_value, output ready);
endinterface

// File: sv/plt_out_if.sv
// Output channel: result value and status, valid/ready handshake.
`timescale 1ns / 1ps

interface plt_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [plt_pkg::DATA_W-1:0]     result_value;
    logic [plt_pkg::STATUS_W-1:0]          status;

    modport source (output valid, result_value, status, input ready);
    modport sink   (input valid, result_value, status, output ready);
endinterface

// File: sv/piecewise_linear_table_lookup_core.sv
// Piecewise-linear lookup table: point memory, binary search, multiply, serial divide.
// Clear, append to an empty or full table and short-table query go straight to the
// response state; other appends first do one memory read of the last point.
// A clamped query compares against the first and last points; an interpolated query
// adds a binary search over the point memory, a multiply and the bit-serial divider.
// One item is worked at a time; a new item is taken while a result waits at the output.
// Synchronous active-low reset empties the table; memory contents are not cleared.
`timescale 1ns / 1ps

module piecewise_linear_table_lookup_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    plt_in_if.sink    i_in,
    plt_out_if.source o_out
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_APP_CHK,
        S_Q_FIRST,
        S_Q_LAST,
        S_Q_SRCH,
        S_Q_CMP,
        S_Q_RDK,
        S_Q_RDK1,
        S_Q_MUL,
        S_Q_DINIT,
        S_Q_DIV,
        S_Q_FIN,
        S_RESP
    } t_state;

    localparam int DW = plt_pkg::DATA_W;
    localparam int IW = plt_pkg::IDX_W;
    localparam int CW = plt_pkg::CNT_W;

    t_state                         r_state;
    logic [CW-1:0]                  r_count;
    logic signed [DW-1:0]           r_x;
    logic signed [DW-1:0]           r_y;
    logic [IW-1:0]                  r_lo;
    logic [IW-1:0]                  r_hi;
    logic signed [DW-1:0]           r_xk;
    logic signed [DW-1:0]           r_yk;
    logic                           r_dy_neg;
    logic                           r_bad;
    logic [DW-1:0]                  r_mag;
    logic [DW-1:0]                  r_dx;
    logic [DW-1:0]                  r_span;
    logic [2*DW-1:0]                r_prod;
    logic [DW-1:0]                  r_rem;
    logic [DW-1:0]                  r_quo;
    logic [plt_pkg::DIV_STEP_W-1:0] r_step;
    logic signed [DW-1:0]           r_res_value;
    logic [plt_pkg::STATUS_W-1:0]   r_res_status;
    logic                           r_out_valid;
    logic signed [DW-1:0]           r_out_value;
    logic [plt_pkg::STATUS_W-1:0]   r_out_status;

    // Point memory, registered read
    plt_pkg::t_point r_mem [plt_pkg::POINTS_MAX];
    plt_pkg::t_point r_rd;
    logic            mem_we;
    logic [IW-1:0]   mem_wa;
    plt_pkg::t_point mem_wd;
    logic [IW-1:0]   mem_ra;

    logic            in_acc;
    logic [CW-1:0]   cnt_m1;
    logic [IW-1:0]   last_idx;
    logic            tbl_full;
    logic [IW-1:0]   srch_diff;
    logic [IW-1:0]   mid;
    logic [DW:0]     dx_w;
    logic [DW:0]     span_w;
    logic [DW:0]     dy_w;
    logic [DW:0]     dy_abs;
    logic [DW:0]     div_t;
    logic            div_ge;
    logic [DW:0]     div_sub;

    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    assign cnt_m1    = r_count - CW'(1);
    assign last_idx  = cnt_m1[IW-1:0];
    assign tbl_full  = (r_count == CW'(plt_pkg::POINTS_MAX));
    assign srch_diff = r_hi - r_lo;
    assign mid       = r_lo + (srch_diff >> 1);

    // Segment differences, 33-bit signed
    assign dx_w   = {r_x[DW-1], r_x} - {r_xk[DW-1], r_xk};
    assign span_w = {r_rd.x[DW-1], r_rd.x} - {r_xk[DW-1], r_xk};
    assign dy_w   = {r_rd.y[DW-1], r_rd.y} - {r_yk[DW-1], r_yk};
    assign dy_abs = dy_w[DW] ? (~dy_w + (DW+1)'(1)) : dy_w;

    // Restoring divide step
    assign div_t   = {r_rem, r_quo[DW-1]};
    assign div_ge  = (div_t >= {1'b0, r_span});
    assign div_sub = div_t - {1'b0, r_span};

    // Memory address and write control
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_count[IW-1:0];
        mem_wd = '{x: r_x, y: r_y};
        mem_ra = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_in.op == plt_pkg::OP_APPEND && !tbl_full) begin
                    if (r_count == '0) begin
                        mem_we = 1'b1;
                        mem_wd = '{x: i_in.x_value, y: i_in.y_value};
                    end else begin
                        mem_ra = last_idx;
                    end
                end
            end
            S_APP_CHK: begin
                mem_we = (r_x > r_rd.x);
            end
            S_Q_FIRST: mem_ra = last_idx;
            S_Q_SRCH:  mem_ra = (srch_diff == IW'(1)) ? r_lo : mid;
            S_Q_RDK:   mem_ra = r_hi;
            default:   mem_ra = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[mem_ra];
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Output drains here; the response state loads it itself
            if (o_out.ready && r_state != S_RESP) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_x         <= i_in.x_value;
                        r_y         <= i_in.y_value;
                        r_res_value <= '0;
                        case (i_in.op)
                            plt_pkg::OP_CLEAR: begin
                                r_count      <= '0;
                                r_res_status <= plt_pkg::ST_CLEARED;
                                r_state      <= S_RESP;
                            end
                            plt_pkg::OP_APPEND: begin
                                if (tbl_full) begin
                                    r_res_status <= plt_pkg::ST_DROPPED;
                                    r_state      <= S_RESP;
                                end else if (r_count == '0) begin
                                    r_count      <= CW'(1);
                                    r_res_status <= plt_pkg::ST_STORED;
                                    r_state      <= S_RESP;
                                end else begin
                                    r_state <= S_APP_CHK;
                                end
                            end
                            plt_pkg::OP_QUERY: begin
                                if (r_count < CW'(2)) begin
                                    r_res_status <= plt_pkg::ST_FEW;
                                    r_state      <= S_RESP;
                                end else begin
                                    r_state <= S_Q_FIRST;
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_APP_CHK: begin
                    // Strictly increasing x only
                    if (r_x > r_rd.x) begin
                        r_count      <= r_count + CW'(1);
                        r_res_status <= plt_pkg::ST_STORED;
                    end else begin
                        r_res_status <= plt_pkg::ST_DROPPED;
                    end
                    r_state <= S_RESP;
                end
                S_Q_FIRST: begin
                    if (r_x <= r_rd.x) begin
                        r_res_value  <= r_rd.y;
                        r_res_status <= plt_pkg::ST_LOW;
                        r_state      <= S_RESP;
                    end else begin
                        r_state <= S_Q_LAST;
                    end
                end
                S_Q_LAST: begin
                    if (r_x >= r_rd.x) begin
                        r_res_value  <= r_rd.y;
                        r_res_status <= plt_pkg::ST_HIGH;
                        r_state      <= S_RESP;
                    end else begin
                        r_lo    <= '0;
                        r_hi    <= last_idx;
                        r_state <= S_Q_SRCH;
                    end
                end
                S_Q_SRCH: begin
                    // Read of mid (or of the lower end when done) issued here
                    r_state <= (srch_diff == IW'(1)) ? S_Q_RDK : S_Q_CMP;
                end
                S_Q_CMP: begin
                    if (r_rd.x <= r_x) begin
                        r_lo <= mid;
                    end else begin
                        r_hi <= mid;
                    end
                    r_state <= S_Q_SRCH;
                end
                S_Q_RDK: begin
                    r_xk    <= r_rd.x;
                    r_yk    <= r_rd.y;
                    r_state <= S_Q_RDK1;
                end
                S_Q_RDK1: begin
                    r_dx     <= dx_w[DW-1:0];
                    r_span   <= span_w[DW-1:0];
                    r_mag    <= dy_abs[DW-1:0];
                    r_dy_neg <= dy_w[DW];
                    r_bad    <= span_w[DW] || (span_w == '0) || dx_w[DW];
                    r_state  <= S_Q_MUL;
                end
                S_Q_MUL: begin
                    r_prod  <= r_mag * r_dx;
                    r_state <= S_Q_DINIT;
                end
                S_Q_DINIT: begin
                    // High half is below the span, so the quotient fits DW bits
                    r_rem   <= r_prod[2*DW-1:DW];
                    r_quo   <= r_prod[DW-1:0];
                    r_step  <= '0;
                    r_state <= S_Q_DIV;
                end
                S_Q_DIV: begin
                    r_rem  <= div_ge ? div_sub[DW-1:0] : div_t[DW-1:0];
                    r_quo  <= {r_quo[DW-2:0], div_ge};
                    r_step <= r_step + plt_pkg::DIV_STEP_W'(1);
                    if (r_step == plt_pkg::DIV_STEP_W'(plt_pkg::DIV_STEPS - 1)) begin
                        r_state <= S_Q_FIN;
                    end
                end
                S_Q_FIN: begin
                    if (r_bad) begin
                        r_res_value <= r_yk;
                    end else if (r_dy_neg) begin
                        r_res_value <= r_yk - $signed(r_quo);
                    end else begin
                        r_res_value <= r_yk + $signed(r_quo);
                    end
                    r_res_status <= plt_pkg::ST_INTERP;
                    r_state      <= S_RESP;
                end
                S_RESP: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_value  <= r_res_value;
                        r_out_status <= r_res_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.result_value = r_out_value;
    assign o_out.status       = r_out_status;

    // Point count never passes the table size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(plt_pkg::POINTS_MAX))
        else $error("point count above table size");

    // Search window stays open while searching
    a_search_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_Q_SRCH || r_state == S_Q_CMP) |-> (r_lo < r_hi))
        else $error("search window collapsed");

    // Memory written only on a stored append
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_IDLE || r_state == S_APP_CHK))
        else $error("memory write outside append");

    // Divider remainder stays below the span
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_Q_DIV && !r_bad) |-> (r_rem < r_span))
        else $error("divider remainder out of range");

    // An appended point advances the count by one
    a_append_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APP_CHK && mem_we) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("append did not advance count");

endmodule
